>>> hdl/halftone_dither_bit_packer_core_defines.svh
// Assertion macros shared by the halftone dither and bit packer modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HALFTONE_DITHER_BIT_PACKER_CORE_DEFINES_SVH
`define HALFTONE_DITHER_BIT_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, off while in reset
`define HTDBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define HTDBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/htdbp_pkg.sv
// Shared types, constants and the Bayer 8x8 threshold table for the
// halftone dither and bit packer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htdbp_pkg;

  // Default line storage depth
  localparam int unsigned MAX_LINE_PIXELS = 8192;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LEN_CFG_W = 14;
  localparam int unsigned ERR_W     = 13;  // stored error, sixteenths of a level
  localparam int unsigned SUM_W     = 15;  // corrected sum before clamping

  // Reset value of the line length register
  localparam logic [LEN_CFG_W-1:0] LINE_PIXELS_RST = 14'd8192;

  // Configuration register indexes
  typedef enum logic {
    REG_DITHER_MODE = 1'b0,
    REG_LINE_PIXELS = 1'b1
  } cfg_reg_t;

  // Dither mode codes
  localparam logic MODE_BAYER = 1'b0;
  localparam logic MODE_FS    = 1'b1;

  // Bayer 8x8 thresholds, index {row[2:0], col[2:0]}
  localparam logic [5:0] BAYER_8X8 [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // Pixel tag handed from the position stage to the diffusion stage
  typedef struct packed {
    logic [PIX_W-1:0] gray_pixel;
    logic             page_start;
    logic             last;
    logic             bayer_bit;
  } pix_tag_t;

endpackage

`default_nettype wire

>>> hdl/htdbp_row_store.sv
// Next-row error store: one write port, one registered read port.
// Depends on htdbp_pkg for the error width.
`timescale 1ns / 1ps
`default_nettype none

module htdbp_row_store #(
  parameter int unsigned DEPTH  = htdbp_pkg::MAX_LINE_PIXELS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire  [ADDR_W-1:0]                     waddr,
  input  wire  logic signed [htdbp_pkg::ERR_W-1:0] wdata,
  input  wire                                   re,
  input  wire  [ADDR_W-1:0]                     raddr,
  output logic signed [htdbp_pkg::ERR_W-1:0]    rdata
);

  logic signed [htdbp_pkg::ERR_W-1:0] mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/htdbp_pos_track.sv
// Position stage: column and row tracking, line end detection, Bayer
// compare and store read issue. Depends on htdbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "halftone_dither_bit_packer_core_defines.svh"

module htdbp_pos_track #(
  parameter int unsigned MAX_LINE_PIXELS = htdbp_pkg::MAX_LINE_PIXELS,
  parameter int unsigned COL_W           = $clog2(MAX_LINE_PIXELS)
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 accept,
  input  wire                                 adv,
  input  wire  [htdbp_pkg::PIX_W-1:0]         gray_pixel,
  input  wire                                 page_start,
  input  wire  [htdbp_pkg::LEN_CFG_W-1:0]     line_pixels,
  output logic                                s1_valid,
  output htdbp_pkg::pix_tag_t                 s1_tag,
  output logic [COL_W-1:0]                    s1_col,
  output logic                                rd_en,
  output logic [COL_W-1:0]                    rd_addr
);

  localparam int unsigned LEN_W = $clog2(MAX_LINE_PIXELS + 1);
  localparam int unsigned CMP_W =
    ((LEN_W > htdbp_pkg::LEN_CFG_W) ? LEN_W : htdbp_pkg::LEN_CFG_W) + 1;

  logic [COL_W-1:0]       col_r, col_nxt, col_cur;
  logic [2:0]             row_r, row_nxt, row_cur;
  logic                   valid_r, valid_nxt;
  htdbp_pkg::pix_tag_t    tag_r, tag_nxt;
  logic [COL_W-1:0]       scol_r;
  logic [CMP_W-1:0]       len_raw, len_eff, col_inc;
  logic                   last;
  logic [5:0]             thr;

  // Clamp the line length to 1..MAX_LINE_PIXELS
  always_comb begin
    len_raw = CMP_W'(line_pixels);
    if (len_raw == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_raw > CMP_W'(MAX_LINE_PIXELS)) begin
      len_eff = CMP_W'(MAX_LINE_PIXELS);
    end else begin
      len_eff = len_raw;
    end
  end

  // Position of this item, page start restarts it
  always_comb begin
    col_cur = page_start ? '0 : col_r;
    row_cur = page_start ? 3'd0 : row_r;
    col_inc = CMP_W'(col_cur) + CMP_W'(1);
    last    = (col_inc >= len_eff);
    col_nxt = last ? '0 : col_inc[COL_W-1:0];
    row_nxt = last ? row_cur + 3'd1 : row_cur;
    thr     = htdbp_pkg::BAYER_8X8[{row_cur, col_cur[2:0]}];
    tag_nxt.gray_pixel = gray_pixel;
    tag_nxt.page_start = page_start;
    tag_nxt.last       = last;
    tag_nxt.bayer_bit  = (gray_pixel[htdbp_pkg::PIX_W-1:2] > thr);
    valid_nxt = accept | (valid_r & ~adv);
  end

  // Advance position and load the stage on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Hold the item payload for the diffusion stage
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r  <= tag_nxt;
      scol_r <= col_cur;
    end
  end

  assign s1_valid = valid_r;
  assign s1_tag   = tag_r;
  assign s1_col   = scol_r;
  assign rd_en    = accept;
  assign rd_addr  = col_cur;

  `HTDBP_ASSERT_NOW(a_col_in_range, 1'b1, 32'(col_r) < 32'(MAX_LINE_PIXELS), "column past line storage")

endmodule

`default_nettype wire

>>> hdl/htdbp_diffuse.sv
// Diffusion stage: corrected value, threshold, error spread into the row
// store with forwarding, and bit packing. Depends on htdbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "halftone_dither_bit_packer_core_defines.svh"

module htdbp_diffuse #(
  parameter int unsigned COL_W = $clog2(htdbp_pkg::MAX_LINE_PIXELS)
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     adv,
  input  wire                                     accept,
  input  wire  [COL_W-1:0]                        rd_addr,
  input  wire  [COL_W-1:0]                        s1_col,
  input  wire  htdbp_pkg::pix_tag_t               s1_tag,
  input  wire                                     dither_mode,
  input  wire  logic signed [htdbp_pkg::ERR_W-1:0] rd_data,
  output logic                                    mem_we,
  output logic [COL_W-1:0]                        mem_waddr,
  output logic signed [htdbp_pkg::ERR_W-1:0]      mem_wdata,
  output logic                                    emit,
  output logic [7:0]                              byte_bits,
  output logic                                    byte_last
);

  localparam int unsigned EW = htdbp_pkg::ERR_W;
  localparam int unsigned SW = htdbp_pkg::SUM_W;

  logic signed [EW-1:0] carry_r, carry_nxt, carry_cur;
  logic signed [EW-1:0] ps0_r, ps0_nxt, ps0_cur;
  logic signed [EW-1:0] ps1_r, ps1_nxt, ps1_cur;
  logic                 first_r, first_nxt, first_cur;
  logic [7:0]           acc_r, acc_nxt, acc_cur, acc_new;
  logic [2:0]           pos_r, pos_nxt, pos_cur;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [COL_W-1:0]     pend_addr_r;
  logic signed [EW-1:0] pend_data_r;
  logic                 fwd_valid_r, fwd_valid_nxt;
  logic signed [EW-1:0] fwd_data_r;
  logic signed [EW-1:0] below, e_x, e3, e5, e7, ps_after;
  logic signed [SW-1:0] sum;
  logic [7:0]           corr;
  logic signed [8:0]    err;
  logic                 fs, bit_fs, pix_bit;
  logic                 dir_we, new_pend;
  logic [COL_W-1:0]     dir_addr;
  logic signed [EW-1:0] dir_data;

  // Track the latest write to the entry held in the read register
  always_comb begin
    fwd_valid_nxt = fwd_valid_r;
    if (accept) begin
      fwd_valid_nxt = mem_we && (mem_waddr == rd_addr);
    end else if (mem_we && (mem_waddr == s1_col)) begin
      fwd_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (accept ? (mem_waddr == rd_addr) : (mem_waddr == s1_col))) begin
      fwd_data_r <= mem_wdata;
    end
  end

  // Page start clears error and packing state ahead of the item
  always_comb begin
    fs        = (dither_mode == htdbp_pkg::MODE_FS);
    carry_cur = s1_tag.page_start ? '0 : carry_r;
    ps0_cur   = s1_tag.page_start ? '0 : ps0_r;
    ps1_cur   = s1_tag.page_start ? '0 : ps1_r;
    first_cur = s1_tag.page_start ? 1'b1 : first_r;
    acc_cur   = s1_tag.page_start ? 8'd0 : acc_r;
    pos_cur   = s1_tag.page_start ? 3'd0 : pos_r;
  end

  // Corrected value, threshold and error
  always_comb begin
    if (first_cur) begin
      below = '0;
    end else if (pend_valid_r && (pend_addr_r == s1_col)) begin
      below = pend_data_r;
    end else if (fwd_valid_r) begin
      below = fwd_data_r;
    end else begin
      below = rd_data;
    end
    sum = $signed({{(SW-htdbp_pkg::PIX_W-4){1'b0}}, s1_tag.gray_pixel, 4'b0000})
          + SW'(carry_cur) + SW'(below);
    if (sum[SW-1]) begin
      corr = 8'd0;
    end else if (|sum[SW-2:12]) begin
      corr = 8'hFF;
    end else begin
      corr = sum[11:4];
    end
    bit_fs = (corr > 8'd128);
    err    = bit_fs ? ($signed({1'b0, corr}) - 9'sd255) : $signed({1'b0, corr});
    e_x    = EW'(err);
    e3     = (e_x <<< 1) + e_x;
    e5     = (e_x <<< 2) + e_x;
    e7     = (e_x <<< 3) - e_x;
    ps_after = ps1_cur + e5;
  end

  // Next error state
  always_comb begin
    carry_nxt = carry_cur;
    ps0_nxt   = ps0_cur;
    ps1_nxt   = ps1_cur;
    first_nxt = first_cur;
    if (fs) begin
      pix_bit   = bit_fs;
      carry_nxt = s1_tag.last ? '0 : e7;
      ps0_nxt   = s1_tag.last ? '0 : ps_after;
      ps1_nxt   = s1_tag.last ? '0 : e_x;
      if (s1_tag.last) begin
        first_nxt = 1'b0;
      end
    end else begin
      pix_bit = s1_tag.bayer_bit;
      if (s1_tag.last) begin
        carry_nxt = '0;
        ps0_nxt   = '0;
        ps1_nxt   = '0;
        first_nxt = 1'b1;
      end
    end
  end

  // Store writes: below-left entry now, own entry at line end via pending slot
  always_comb begin
    dir_we   = adv && fs && (s1_col != '0);
    dir_addr = s1_col - COL_W'(1);
    dir_data = ps0_cur + e3;
    new_pend = adv && fs && s1_tag.last;
    mem_we    = dir_we | pend_valid_r;
    mem_waddr = dir_we ? dir_addr : pend_addr_r;
    mem_wdata = dir_we ? dir_data : pend_data_r;
    pend_valid_nxt = new_pend | (pend_valid_r & dir_we);
  end

  // Pack bits MSB first
  always_comb begin
    acc_new   = acc_cur | ({7'd0, pix_bit} << (3'd7 - pos_cur));
    emit      = adv && ((pos_cur == 3'd7) || s1_tag.last);
    byte_bits = acc_new;
    byte_last = s1_tag.last;
    acc_nxt   = ((pos_cur == 3'd7) || s1_tag.last) ? 8'd0 : acc_new;
    pos_nxt   = ((pos_cur == 3'd7) || s1_tag.last) ? 3'd0 : pos_cur + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r      <= '0;
      ps0_r        <= '0;
      ps1_r        <= '0;
      first_r      <= 1'b1;
      acc_r        <= 8'd0;
      pos_r        <= 3'd0;
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      if (adv) begin
        carry_r <= carry_nxt;
        ps0_r   <= ps0_nxt;
        ps1_r   <= ps1_nxt;
        first_r <= first_nxt;
        acc_r   <= acc_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  // Hold the line-end entry until the write port is free
  always_ff @(posedge clk) begin
    if (new_pend) begin
      pend_addr_r <= s1_col;
      pend_data_r <= ps_after;
    end
  end

  `HTDBP_ASSERT_NOW(a_pend_not_blocked, pend_valid_r, !dir_we, "pending write blocked")
  `HTDBP_ASSERT_NEXT(a_fs_line_clears_first, new_pend, !first_r, "first-row flag left set")

endmodule

`default_nettype wire

>>> hdl/halftone_dither_bit_packer_core.sv
// Top level of the halftone dither and bit packer: configuration registers,
// handshakes, output register. Depends on htdbp_pkg, htdbp_pos_track,
// htdbp_row_store and htdbp_diffuse.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_gray_pixel, in_page_start
//   out     | output    | out_valid/out_ready| out_packed_bits, out_line_end
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One pixel item per cycle unless the output stalls. A byte's last pixel is
// registered in the position stage, then the byte in the output register.
// The error carry to the right closes in the diffusion stage; the row store
// takes one read and one write per cycle. Synchronous active-low reset
// clears position, error and packing state; the row store is not cleared.
// A stalled output holds the diffusion stage and then the input.
`timescale 1ns / 1ps
`default_nettype none

module halftone_dither_bit_packer_core #(
  parameter int unsigned MAX_LINE_PIXELS = htdbp_pkg::MAX_LINE_PIXELS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [htdbp_pkg::PIX_W-1:0]       in_gray_pixel,
  input  wire                               in_page_start,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [7:0]                        out_packed_bits,
  output logic                              out_line_end,
  input  wire                               cfg_we,
  input  wire                               cfg_index,
  input  wire  [htdbp_pkg::LEN_CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned COL_W = $clog2(MAX_LINE_PIXELS);

  logic                                mode_r;
  logic [htdbp_pkg::LEN_CFG_W-1:0]     line_pixels_r;
  logic                                accept, adv;
  logic                                s1_valid;
  htdbp_pkg::pix_tag_t                 s1_tag;
  logic [COL_W-1:0]                    s1_col, rd_addr, mem_waddr;
  logic                                rd_en, mem_we;
  logic signed [htdbp_pkg::ERR_W-1:0]  rd_data, mem_wdata;
  logic                                emit, byte_last;
  logic [7:0]                          byte_bits;
  logic                                out_valid_r;
  logic [7:0]                          out_bits_r;
  logic                                out_last_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= htdbp_pkg::MODE_BAYER;
      line_pixels_r <= htdbp_pkg::LINE_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (htdbp_pkg::cfg_reg_t'(cfg_index))
        htdbp_pkg::REG_DITHER_MODE: mode_r <= cfg_wdata[0];
        htdbp_pkg::REG_LINE_PIXELS: line_pixels_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshakes: the diffusion stage moves when the output slot is free
  assign adv      = s1_valid && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid || adv;
  assign accept   = in_valid && in_ready;

  htdbp_pos_track #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .COL_W           (COL_W)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .adv         (adv),
    .gray_pixel  (in_gray_pixel),
    .page_start  (in_page_start),
    .line_pixels (line_pixels_r),
    .s1_valid    (s1_valid),
    .s1_tag      (s1_tag),
    .s1_col      (s1_col),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  htdbp_row_store #(
    .DEPTH  (MAX_LINE_PIXELS),
    .ADDR_W (COL_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  htdbp_diffuse #(
    .COL_W (COL_W)
  ) u_diffuse (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .accept      (accept),
    .rd_addr     (rd_addr),
    .s1_col      (s1_col),
    .s1_tag      (s1_tag),
    .dither_mode (mode_r),
    .rd_data     (rd_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .emit        (emit),
    .byte_bits   (byte_bits),
    .byte_last   (byte_last)
  );

  // Output register: load a finished byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bits_r <= byte_bits;
      out_last_r <= byte_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_bits = out_bits_r;
  assign out_line_end    = out_last_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_halftone_dither_bit_packer_core.sv
// Self-checking testbench for halftone_dither_bit_packer_core: a directed
// table, then random pages under both dither modes, checked against a
// behavioral predictor. Depends on htdbp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_halftone_dither_bit_packer_core;

  localparam int RAND_ITEMS = 1350;
  localparam int DRAIN_PAD  = 8;
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_LINE   = htdbp_pkg::MAX_LINE_PIXELS;

  typedef struct packed {
    logic [7:0] bits;
    logic       line_end;
  } halftone_byte_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_MODE, ROW_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [13:0] value;
    logic        page_start;
    logic        typed;
    logic [7:0]  exp_bits;
    logic        exp_end;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_gray_pixel = 8'd0;
  logic                  in_page_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_packed_bits;
  logic                  out_line_end;
  logic                  cfg_we = 1'b0;
  htdbp_pkg::cfg_reg_t   cfg_index = htdbp_pkg::REG_DITHER_MODE;
  logic [13:0]           cfg_wdata = 14'd0;

  halftone_dither_bit_packer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_gray_pixel   (in_gray_pixel),
    .in_page_start   (in_page_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_bits (out_packed_bits),
    .out_line_end    (out_line_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Bayer 8x8 thresholds, [row][column]
  logic [5:0] bayer_thr [8][8] = '{
    '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
    '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
    '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
    '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
    '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
    '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
    '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
    '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
  };

  // Directed table: lengths 0 and over range, partial byte dropped by page
  // start, length shrunk below the column, FS threshold at 128, mode swaps
  // in the middle of a line
  plan_row_t dir_plan [32] = '{
    '{ROW_LEN,   14'd0,     1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b1, 1'b1, 8'h80, 1'b1},
    '{ROW_PIXEL, 14'd0,     1'b0, 1'b1, 8'h00, 1'b1},
    '{ROW_LEN,   14'd16383, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b1, 8'hFF, 1'b0},
    '{ROW_LEN,   14'd4,     1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b1, 8'h80, 1'b1},
    '{ROW_MODE,  14'(htdbp_pkg::MODE_FS), 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_LEN,   14'd3,     1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd128,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd0,     1'b0, 1'b1, 8'h80, 1'b1},
    '{ROW_PIXEL, 14'd129,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd0,     1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd0,     1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd200,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd60,    1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_MODE,  14'(htdbp_pkg::MODE_BAYER), 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd100,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_MODE,  14'(htdbp_pkg::MODE_FS), 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd255,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_PIXEL, 14'd10,    1'b0, 1'b0, 8'h00, 1'b0}
  };

  // Predictor state
  logic        mode_q;
  int          line_len_q;
  logic [12:0] col_q;
  logic [2:0]  row_q;
  bit          first_row_q;
  int          carry_q;
  int          below_sum0, below_sum1;
  int          err_row    [MAX_LINE];
  bit          err_row_ok [MAX_LINE];
  logic [7:0]  acc_q;
  logic [2:0]  bitpos_q;

  halftone_byte_t exp_bytes [$];
  int             err_count = 0;
  bit             src_burst = 1'b0;
  bit             sink_burst = 1'b0;
  int             stall_left = 0;
  int             sink_gap = 0;
  int             idle_cycles = 0;
  halftone_byte_t head;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic void clear_page();
    col_q       = '0;
    row_q       = '0;
    first_row_q = 1'b1;
    carry_q     = 0;
    below_sum0  = 0;
    below_sum1  = 0;
    acc_q       = '0;
    bitpos_q    = '0;
  endfunction

  function automatic void store_err(input int idx, input int v);
    err_row[idx]    = v;
    err_row_ok[idx] = 1'b1;
  endfunction

  // Dither one pixel; returns 1 when a packed byte leaves
  function automatic bit halftone_pixel(input logic [7:0] pix, input logic ps,
                                        output halftone_byte_t pk);
    int   len, below, s, c, e;
    logic b;
    bit   line_done;
    if (ps) clear_page();
    len = line_len_q;
    if (len < 1) len = 1;
    if (len > MAX_LINE) len = MAX_LINE;
    line_done = (int'(col_q) + 1 >= len);
    pk = '0;

    if (mode_q == htdbp_pkg::MODE_FS) begin
      below = first_row_q ? 0 : err_row[col_q];
      s = 16 * int'(pix) + carry_q + below;
      if (s < 0) begin
        c = 0;
      end else begin
        c = s / 16;
        if (c > 255) c = 255;
      end
      b = (c > 128);
      e = b ? c - 255 : c;
      // diffuse below-left, below, below-right into the row store
      if (col_q > 0) store_err(int'(col_q) - 1, below_sum0 + 3 * e);
      below_sum0 = below_sum1 + 5 * e;
      below_sum1 = e;
      carry_q = line_done ? 0 : 7 * e;
      if (line_done) begin
        store_err(int'(col_q), below_sum0);
        below_sum0  = 0;
        below_sum1  = 0;
        first_row_q = 1'b0;
      end
    end else begin
      b = ({2'b00, pix[7:2]} > {2'b00, bayer_thr[row_q][col_q[2:0]]});
      if (line_done) begin
        first_row_q = 1'b1;
        carry_q     = 0;
        below_sum0  = 0;
        below_sum1  = 0;
      end
    end

    if (b) acc_q[3'd7 - bitpos_q] = 1'b1;
    if (line_done) begin
      col_q = '0;
      row_q = row_q + 3'd1;
    end else begin
      col_q = col_q + 13'd1;
    end

    if (bitpos_q == 3'd7 || line_done) begin
      pk.bits     = acc_q;
      pk.line_end = line_done;
      acc_q       = '0;
      bitpos_q    = '0;
      return 1'b1;
    end
    bitpos_q = bitpos_q + 3'd1;
    return 1'b0;
  endfunction

  // Present one pixel, hold it until accepted, then predict it
  task automatic send_pixel(input logic [7:0] pix, input logic ps,
                            output bit has, output halftone_byte_t pk);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_gray_pixel <= pix;
    in_page_start <= ps;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = halftone_pixel(pix, ps, pk);
  endtask

  // Drain every expected byte, then let in-flight pixels settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic program_regs(input bit wr_mode, input logic mode,
                              input bit wr_len, input int len);
    if (wr_mode) begin
      cfg_we    <= 1'b1;
      cfg_index <= htdbp_pkg::REG_DITHER_MODE;
      cfg_wdata <= 14'(mode);
      @(posedge clk);
      mode_q = mode;
    end
    if (wr_len) begin
      cfg_we    <= 1'b1;
      cfg_index <= htdbp_pkg::REG_LINE_PIXELS;
      cfg_wdata <= 14'(len);
      @(posedge clk);
      line_len_q = len & 16'h3FFF;
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_line_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 9);
    if (r < 70) return $urandom_range(10, 40);
    if (r < 82) return $urandom_range(41, 300);
    if (r < 87) return 0;
    if (r < 92) return MAX_LINE;
    if (r < 96) return MAX_LINE + 1;
    return 16383;
  endfunction

  function automatic logic [7:0] pick_gray();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r < 4) return 8'($urandom_range(120, 136));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result sink: random stall per byte, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (exp_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", out_packed_bits, 0);
      end else begin
        head = exp_bytes.pop_front();
        if (out_packed_bits !== head.bits)
          report_mismatch("packed_bits", out_packed_bits, head.bits);
        if (out_line_end !== head.line_end)
          report_mismatch("line_end", out_line_end, head.line_end);
      end
      sink_gap = sink_burst ? 0 : $urandom_range(0, 7);
      stall_left <= sink_gap;
      out_ready  <= (sink_gap == 0);
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    plan_row_t      row;
    halftone_byte_t pk;
    bit             has, ps, fresh_page;
    int             sent, n, choice;
    logic [7:0]     pix;

    mode_q     = htdbp_pkg::MODE_BAYER;
    line_len_q = MAX_LINE;
    clear_page();
    foreach (err_row_ok[i]) err_row_ok[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_plan[i]) begin
      row = dir_plan[i];
      case (row.kind)
        ROW_MODE: begin
          wait_idle();
          program_regs(1'b1, row.value[0], 1'b0, 0);
        end
        ROW_LEN: begin
          wait_idle();
          program_regs(1'b0, htdbp_pkg::MODE_BAYER, 1'b1, int'(row.value));
        end
        default: begin
          send_pixel(row.value[7:0], row.page_start, has, pk);
          if (row.typed) begin
            if (!has || pk != {row.exp_bits, row.exp_end})
              report_mismatch("table row vs predictor", pk, {row.exp_bits, row.exp_end});
            exp_bytes.push_back({row.exp_bits, row.exp_end});
          end else if (has) begin
            exp_bytes.push_back(pk);
          end
        end
      endcase
    end

    // Random phases, each under one register setting
    sent = 0;
    while (sent < RAND_ITEMS) begin
      wait_idle();
      choice = $urandom_range(0, 2);
      program_regs(choice != 1, logic'($urandom_range(0, 1)), choice != 0, pick_line_len());
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      fresh_page = $urandom_range(0, 1);
      n = $urandom_range(16, 80);
      for (int k = 0; k < n; k++) begin
        ps = (k == 0 && fresh_page) || ($urandom_range(0, 39) == 0);
        // never read a row store entry that was not written
        if (mode_q == htdbp_pkg::MODE_FS && !first_row_q && !ps && !err_row_ok[col_q])
          ps = 1'b1;
        pix = pick_gray();
        send_pixel(pix, ps, has, pk);
        if (has) exp_bytes.push_back(pk);
        sent++;
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
